[sv/rpn_four_level_stack_alu_top_macros.svh]
// ----------------------------------------------------------------------------
// RPN stack ALU assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef RPN_FOUR_LEVEL_STACK_ALU_TOP_MACROS_SVH
`define RPN_FOUR_LEVEL_STACK_ALU_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define RPN4_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define RPN4_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define RPN4_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define RPN4_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

[sv/rpn4_pkg.sv]
// ----------------------------------------------------------------------------
// RPN stack ALU package
// Transaction types, action codes, fixed-point limits and FSM states.
// ----------------------------------------------------------------------------
package rpn4_pkg;

	localparam int DATA_W        = 64;
	localparam int FRAC_BITS_DEF = 16;
	localparam int ACT_W         = 3;

	// Action codes
	localparam logic [ACT_W-1:0] ACT_PUSH = 3'd0;
	localparam logic [ACT_W-1:0] ACT_ADD  = 3'd1;
	localparam logic [ACT_W-1:0] ACT_SUB  = 3'd2;
	localparam logic [ACT_W-1:0] ACT_MUL  = 3'd3;
	localparam logic [ACT_W-1:0] ACT_DIV  = 3'd4;

	// Saturation limits
	localparam logic [DATA_W-1:0] NEG_LIMIT = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic [DATA_W-1:0] POS_LIMIT = {1'b0, {(DATA_W-1){1'b1}}};

	typedef struct packed {
		logic [ACT_W-1:0]         action;
		logic signed [DATA_W-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] x_reg;
		logic signed [DATA_W-1:0] y_reg;
		logic signed [DATA_W-1:0] z_reg;
		logic signed [DATA_W-1:0] t_reg;
		logic                     divide_error;
		logic                     saturated;
	} res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADDSUB,
		ST_ABS_A,
		ST_ABS_B,
		ST_LOOP,
		ST_FIX,
		ST_DONE
	} state_t;

endpackage

[sv/rpn_four_level_stack_alu_top.sv]
// ----------------------------------------------------------------------------
// RPN four-level stack ALU
// X/Y/Z/T stack with saturating fixed-point add, subtract, multiply, divide.
// ----------------------------------------------------------------------------
//  channel | signals                  | direction | payload
//  cmd     | cmd_valid, cmd_stall     | in        | rpn4_pkg::cmd_t
//  res     | res_valid, res_stall     | out       | rpn4_pkg::res_t
//
//  One transaction in flight; cmd_stall is high from accept until the result
//  is loaded into the output register. Push, unknown action and divide by
//  zero go straight to the final state; add and subtract pass the adder once;
//  multiply takes magnitudes, then 64 shift-add steps on one 66-bit adder;
//  divide likewise, one restoring step per quotient bit; both then clamp.
//  A held res_stall keeps the next result waiting in the final state while the output register still holds a result.
//  Reset clears the stack to zero; no clearing pass.
// ----------------------------------------------------------------------------
`include "rpn_four_level_stack_alu_top_macros.svh"

module rpn_four_level_stack_alu_top #(
	parameter int FRAC_BITS = rpn4_pkg::FRAC_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_stall,
	input  rpn4_pkg::cmd_t cmd,
	output logic           res_valid,
	input  logic           res_stall,
	output rpn4_pkg::res_t res
);
	import rpn4_pkg::*;

	localparam int LO_W      = DATA_W + FRAC_BITS;
	localparam int MUL_STEPS = DATA_W;
	localparam int CNT_W     = $clog2(LO_W);
	localparam int ALU_W     = DATA_W + 2;
	localparam int PROD_W    = 2 * DATA_W;

	state_t state_q, state_d;

	// Stack levels
	logic [DATA_W-1:0] x_q, y_q, z_q, t_q;
	logic [DATA_W-1:0] x_d, y_d, z_d, t_d;

	// Transaction context
	logic [ACT_W-1:0]  op_q;
	logic [DATA_W-1:0] value_q;
	logic              neg_q;
	logic              derr_q;
	logic              sat_q;
	logic [DATA_W-1:0] r_q;

	// Iteration registers: hi_q is accumulator / remainder, lo_q the shifting word
	logic [DATA_W-1:0] hi_q;
	logic [LO_W-1:0]   lo_q;
	logic [DATA_W-1:0] b_q;
	logic [CNT_W-1:0]  cnt_q;

	logic res_valid_q;
	res_t res_q;

	// Shared adder
	logic [ALU_W-1:0] alu_a, alu_b, alu_sum;
	logic             alu_sub;

	assign alu_sum = alu_a + (alu_b ^ {ALU_W{alu_sub}}) + ALU_W'(alu_sub);

	logic cmd_fire;
	logic res_free;
	logic load_res;

	assign cmd_fire = cmd_valid && !cmd_stall;
	assign res_free = !res_valid_q || !res_stall;

	// Step bits
	logic div_bit, div_qbit, mul_bit;
	assign div_bit  = lo_q[LO_W-1];
	assign div_qbit = !alu_sum[ALU_W-1];
	assign mul_bit  = lo_q[0];

	// Wide result views for the final clamp
	logic [PROD_W-1:0] prod_w, prod_sh, quot_w;
	logic [DATA_W-1:0] fix_lo;
	logic              fix_hinz;

	assign prod_w  = {hi_q, lo_q[LO_W-1:FRAC_BITS]};
	assign prod_sh = prod_w >> FRAC_BITS;
	assign quot_w  = PROD_W'(lo_q);

	always_comb begin
		if (op_q == ACT_MUL) begin
			fix_lo   = prod_sh[DATA_W-1:0];
			fix_hinz = |prod_sh[PROD_W-1:DATA_W];
		end else begin
			fix_lo   = quot_w[DATA_W-1:0];
			fix_hinz = |quot_w[PROD_W-1:DATA_W];
		end
	end

	// Add / subtract overflow
	logic [DATA_W-1:0] as_sum;
	logic              as_ovf;

	assign as_sum = alu_sum[DATA_W-1:0];
	always_comb begin
		if (op_q == ACT_SUB) begin
			as_ovf = (y_q[DATA_W-1] ^ x_q[DATA_W-1]) & (y_q[DATA_W-1] ^ as_sum[DATA_W-1]);
		end else begin
			as_ovf = ~(y_q[DATA_W-1] ^ x_q[DATA_W-1]) & (y_q[DATA_W-1] ^ as_sum[DATA_W-1]);
		end
	end

	// Clamp of the mul/div magnitude
	logic fix_sat;
	always_comb begin
		if (neg_q) begin
			fix_sat = fix_hinz || (fix_lo[DATA_W-1] && (|fix_lo[DATA_W-2:0]));
		end else begin
			fix_sat = fix_hinz || fix_lo[DATA_W-1];
		end
	end

	// Next state, adder operands
	always_comb begin
		state_d  = state_q;
		alu_a    = '0;
		alu_b    = '0;
		alu_sub  = 1'b0;
		load_res = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_fire) begin
					priority if (cmd.action == ACT_ADD || cmd.action == ACT_SUB) begin
						state_d = ST_ADDSUB;
					end else if (cmd.action == ACT_MUL) begin
						state_d = ST_ABS_A;
					end else if (cmd.action == ACT_DIV && x_q != '0) begin
						state_d = ST_ABS_A;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_ADDSUB: begin
				alu_a   = ALU_W'(y_q);
				alu_b   = ALU_W'(x_q);
				alu_sub = (op_q == ACT_SUB);
				state_d = ST_DONE;
			end
			ST_ABS_A: begin
				alu_b   = ALU_W'(y_q);
				alu_sub = 1'b1;
				state_d = ST_ABS_B;
			end
			ST_ABS_B: begin
				alu_b   = ALU_W'(x_q);
				alu_sub = 1'b1;
				state_d = ST_LOOP;
			end
			ST_LOOP: begin
				if (op_q == ACT_MUL) begin
					alu_a = ALU_W'(hi_q);
					alu_b = mul_bit ? ALU_W'(b_q) : '0;
				end else begin
					alu_a   = ALU_W'({hi_q, div_bit});
					alu_b   = ALU_W'(b_q);
					alu_sub = 1'b1;
				end
				if (cnt_q == '0) begin
					state_d = ST_FIX;
				end
			end
			ST_FIX: begin
				alu_b   = ALU_W'(fix_lo);
				alu_sub = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (res_free) begin
					load_res = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign cmd_stall = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Datapath and context registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_fire) begin
					op_q    <= cmd.action;
					value_q <= cmd.value;
					neg_q   <= y_q[DATA_W-1] ^ x_q[DATA_W-1];
					derr_q  <= (cmd.action == ACT_DIV) && (x_q == '0);
					sat_q   <= 1'b0;
				end
			end
			ST_ADDSUB: begin
				sat_q <= as_ovf;
				r_q   <= as_ovf ? (y_q[DATA_W-1] ? NEG_LIMIT : POS_LIMIT) : as_sum;
			end
			ST_ABS_A: begin
				hi_q <= '0;
				if (op_q == ACT_MUL) begin
					lo_q <= LO_W'(y_q[DATA_W-1] ? alu_sum[DATA_W-1:0] : y_q);
				end else begin
					lo_q <= LO_W'(y_q[DATA_W-1] ? alu_sum[DATA_W-1:0] : y_q) << FRAC_BITS;
				end
			end
			ST_ABS_B: begin
				b_q   <= x_q[DATA_W-1] ? alu_sum[DATA_W-1:0] : x_q;
				cnt_q <= (op_q == ACT_MUL) ? CNT_W'(MUL_STEPS - 1) : CNT_W'(LO_W - 1);
			end
			ST_LOOP: begin
				cnt_q <= cnt_q - 1'b1;
				if (op_q == ACT_MUL) begin
					hi_q <= alu_sum[DATA_W:1];
					lo_q <= {alu_sum[0], lo_q[LO_W-1:1]};
				end else begin
					hi_q <= div_qbit ? alu_sum[DATA_W-1:0] : {hi_q[DATA_W-2:0], div_bit};
					lo_q <= {lo_q[LO_W-2:0], div_qbit};
				end
			end
			ST_FIX: begin
				sat_q <= fix_sat;
				priority if (fix_sat) begin
					r_q <= neg_q ? NEG_LIMIT : POS_LIMIT;
				end else if (neg_q) begin
					r_q <= alu_sum[DATA_W-1:0];
				end else begin
					r_q <= fix_lo;
				end
			end
			ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	// Stack update for the finished transaction
	always_comb begin
		x_d = x_q;
		y_d = y_q;
		z_d = z_q;
		t_d = t_q;
		if (op_q == ACT_PUSH) begin
			x_d = value_q;
			y_d = x_q;
			z_d = y_q;
			t_d = z_q;
		end else if ((op_q == ACT_ADD || op_q == ACT_SUB || op_q == ACT_MUL ||
			op_q == ACT_DIV) && !derr_q) begin
			x_d = r_q;
			y_d = z_q;
			z_d = t_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= '0;
			y_q <= '0;
			z_q <= '0;
			t_q <= '0;
		end else if (load_res) begin
			x_q <= x_d;
			y_q <= y_d;
			z_q <= z_d;
			t_q <= t_d;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load_res) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			res_q.x_reg        <= x_d;
			res_q.y_reg        <= y_d;
			res_q.z_reg        <= z_d;
			res_q.t_reg        <= t_d;
			res_q.divide_error <= derr_q;
			res_q.saturated    <= sat_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// Checks
	`RPN4_ASSERT_NEXT(a_accept_leaves_idle, clk, arst_n, cmd_fire, state_q != ST_IDLE, "accepted transaction did not start")
	`RPN4_ASSERT_NEXT(a_done_loads_result, clk, arst_n, state_q == ST_DONE && res_free, res_valid && state_q == ST_IDLE, "finished transaction not delivered")
	`RPN4_ASSERT_NOW(a_flags_exclusive, clk, arst_n, res_valid, !(res.divide_error && res.saturated), "divide error and saturation both set")
	`RPN4_ASSERT_NEXT(a_loop_exit, clk, arst_n, state_q == ST_LOOP && cnt_q == '0, state_q == ST_FIX, "iteration did not end at zero count")

endmodule

[tb/tb_rpn_four_level_stack_alu_top.sv]
// ----------------------------------------------------------------------------
// RPN four-level stack ALU testbench
// Drives push, arithmetic and unused action commands through the valid/stall channels and
// checks every result against a predicted copy of the X/Y/Z/T stack.
// Includes directed saturation and divide-by-zero cases, then random traffic
// under three idle/stall mixes.
// ----------------------------------------------------------------------------

// Tracks the stack and holds the expected result of each accepted command
class rpn_stack_tracker;
	localparam int FB = rpn4_pkg::FRAC_BITS_DEF;

	logic [63:0]     level[4];   // 0 = X, 1 = Y, 2 = Z, 3 = T
	rpn4_pkg::res_t  expected_stacks[$];
	int              errs;

	function new();
		foreach (level[i]) level[i] = '0;
		errs = 0;
	endfunction

	// Clamp a magnitude with sign into the 64-bit signed range
	function logic [63:0] clamp_mag(logic [127:0] mag, bit neg, inout bit sat);
		if (neg) begin
			if (mag > {64'd0, rpn4_pkg::NEG_LIMIT}) begin
				sat = 1'b1;
				return rpn4_pkg::NEG_LIMIT;
			end
			return -mag[63:0];
		end
		if (mag > {64'd0, rpn4_pkg::POS_LIMIT}) begin
			sat = 1'b1;
			return rpn4_pkg::POS_LIMIT;
		end
		return mag[63:0];
	endfunction

	function logic [63:0] sat_addsub(logic [63:0] a, logic [63:0] b, bit sub, inout bit sat);
		logic [64:0] s;
		s = sub ? ({a[63], a} - {b[63], b}) : ({a[63], a} + {b[63], b});
		// top two bits disagree: left the 64-bit range
		if (s[64] != s[63]) begin
			sat = 1'b1;
			return s[64] ? rpn4_pkg::NEG_LIMIT : rpn4_pkg::POS_LIMIT;
		end
		return s[63:0];
	endfunction

	function logic [63:0] sat_mul(logic [63:0] a, logic [63:0] b, inout bit sat);
		logic [127:0] ma, mb, prod;
		ma = {64'd0, (a[63] ? -a : a)};
		mb = {64'd0, (b[63] ? -b : b)};
		prod = (ma * mb) >> FB;
		return clamp_mag(prod, a[63] ^ b[63], sat);
	endfunction

	function logic [63:0] sat_div(logic [63:0] a, logic [63:0] b, inout bit sat);
		logic [127:0] num, den, quo;
		num = {64'd0, (a[63] ? -a : a)} << FB;
		den = {64'd0, (b[63] ? -b : b)};
		quo = num / den;
		return clamp_mag(quo, a[63] ^ b[63], sat);
	endfunction

	// Advance the stack by one accepted command and queue the expected result
	function void predict_step(rpn4_pkg::cmd_t c);
		rpn4_pkg::res_t r;
		logic [63:0]    x, y, v;
		bit             sat, derr, apply;
		x = level[0];
		y = level[1];
		v = '0;
		sat = 1'b0;
		derr = 1'b0;
		apply = 1'b1;
		case (c.action)
			rpn4_pkg::ACT_PUSH: begin
				level[3] = level[2];
				level[2] = level[1];
				level[1] = level[0];
				level[0] = c.value;
				apply = 1'b0;
			end
			rpn4_pkg::ACT_ADD: v = sat_addsub(y, x, 1'b0, sat);
			rpn4_pkg::ACT_SUB: v = sat_addsub(y, x, 1'b1, sat);
			rpn4_pkg::ACT_MUL: v = sat_mul(y, x, sat);
			rpn4_pkg::ACT_DIV: begin
				// divide by zero leaves the whole stack alone
				if (x == '0) begin
					derr = 1'b1;
					apply = 1'b0;
				end else begin
					v = sat_div(y, x, sat);
				end
			end
			default: apply = 1'b0;
		endcase
		// operation drops the stack; T keeps its value
		if (apply) begin
			level[0] = v;
			level[1] = level[2];
			level[2] = level[3];
		end
		r.x_reg = level[0];
		r.y_reg = level[1];
		r.z_reg = level[2];
		r.t_reg = level[3];
		r.divide_error = derr;
		r.saturated = sat;
		expected_stacks.push_back(r);
	endfunction

	function void cmp(string name, logic [63:0] e, logic [63:0] a);
		if (a !== e) begin
			$error("%s: expected %h, got %h", name, e, a);
			errs++;
		end
	endfunction

	// Compare one result transaction with the oldest expectation
	function void check_stack(rpn4_pkg::res_t got);
		rpn4_pkg::res_t e;
		if (expected_stacks.size() == 0) begin
			$error("result transaction with no command outstanding");
			errs++;
			return;
		end
		e = expected_stacks.pop_front();
		cmp("x_reg", e.x_reg, got.x_reg);
		cmp("y_reg", e.y_reg, got.y_reg);
		cmp("z_reg", e.z_reg, got.z_reg);
		cmp("t_reg", e.t_reg, got.t_reg);
		cmp("divide_error", 64'(e.divide_error), 64'(got.divide_error));
		cmp("saturated", 64'(e.saturated), 64'(got.saturated));
	endfunction

	function int pending();
		return expected_stacks.size();
	endfunction
endclass

module tb_rpn_four_level_stack_alu_top;
	import rpn4_pkg::*;

	// Unused action codes; the block must ignore them
	localparam logic [ACT_W-1:0] ACT_SPARE_A = 3'd5;
	localparam logic [ACT_W-1:0] ACT_SPARE_B = 3'd6;
	localparam logic [ACT_W-1:0] ACT_SPARE_C = 3'd7;

	localparam logic [63:0] FX_ONE       = 64'd1 << FRAC_BITS_DEF;
	localparam int          CYCLE_LIMIT  = 1_000_000;
	localparam int          RANDOM_ITEMS = 500;   // per idle phase
	localparam int          DRAIN_CYCLES = 120;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	cmd_t cmd       = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_t res;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int cycles = 0;

	rpn_stack_tracker tracker = new();

	rpn_four_level_stack_alu_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	always #2 clk = ~clk;

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Receiver back-pressure
	always @(negedge clk) begin
		res_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	// Result monitor
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall)
			tracker.check_stack(res);
	end

	// Present one command, hold it until accepted; called and returns at negedge
	task automatic send_cmd(input logic [ACT_W-1:0] act, input logic [63:0] val);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			cmd_valid = 1'b0;
			@(negedge clk);
		end
		cmd_valid = 1'b1;
		cmd.action = act;
		cmd.value = val;
		do @(posedge clk); while (cmd_stall);
		tracker.predict_step(cmd);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		cmd_valid = 1'b0;
		while (tracker.pending() != 0) @(negedge clk);
	endtask

	function automatic logic [63:0] rand_word();
		return {$urandom(), $urandom()};
	endfunction

	// Operand mix: full range, small and mid fixed-point values, edges, zero, signed powers of two
	function automatic logic [63:0] pick_value();
		logic [63:0] r;
		r = rand_word();
		case ($urandom_range(0, 9))
			0, 1, 2: return r;
			3, 4, 5: return {{40{r[23]}}, r[23:0]};
			6:       return {{24{r[39]}}, r[39:0]};
			7: begin
				case ($urandom_range(0, 6))
					0: return POS_LIMIT;
					1: return NEG_LIMIT;
					2: return 64'd1;
					3: return '1;
					4: return FX_ONE;
					5: return -FX_ONE;
					default: return POS_LIMIT - 64'd1;
				endcase
			end
			8:       return '0;
			default: begin
				r = 64'd1 << $urandom_range(0, 63);
				return $urandom_range(0, 1) ? -r : r;
			end
		endcase
	endfunction

	function automatic logic [ACT_W-1:0] pick_action();
		int p;
		p = $urandom_range(0, 99);
		if (p < 40) return ACT_PUSH;
		if (p < 54) return ACT_ADD;
		if (p < 68) return ACT_SUB;
		if (p < 82) return ACT_MUL;
		if (p < 96) return ACT_DIV;
		case ($urandom_range(0, 2))
			0:       return ACT_SPARE_A;
			1:       return ACT_SPARE_B;
			default: return ACT_SPARE_C;
		endcase
	endfunction

	task automatic run_random(input int n);
		for (int i = 0; i < n; i++)
			send_cmd(pick_action(), pick_value());
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_idle_pct = 11;
		recv_stall_pct = 80;

		// positive add overflow
		send_cmd(ACT_PUSH, POS_LIMIT);
		send_cmd(ACT_PUSH, FX_ONE);
		send_cmd(ACT_ADD, rand_word());
		// negative subtract overflow
		send_cmd(ACT_PUSH, NEG_LIMIT);
		send_cmd(ACT_PUSH, 64'd1);
		send_cmd(ACT_SUB, rand_word());
		// divide by zero
		send_cmd(ACT_PUSH, '0);
		send_cmd(ACT_DIV, rand_word());
		// most negative divided by -1.0
		send_cmd(ACT_PUSH, NEG_LIMIT);
		send_cmd(ACT_PUSH, -FX_ONE);
		send_cmd(ACT_DIV, rand_word());
		// multiply overflow, both signs
		send_cmd(ACT_PUSH, POS_LIMIT);
		send_cmd(ACT_PUSH, POS_LIMIT);
		send_cmd(ACT_MUL, rand_word());
		send_cmd(ACT_PUSH, NEG_LIMIT);
		send_cmd(ACT_PUSH, FX_ONE << 1);
		send_cmd(ACT_MUL, rand_word());
		// exact product 3.5 * -2.25, then exact divide by 7.0
		send_cmd(ACT_PUSH, 64'h38000);
		send_cmd(ACT_PUSH, -64'h24000);
		send_cmd(ACT_MUL, rand_word());
		send_cmd(ACT_PUSH, FX_ONE * 7);
		send_cmd(ACT_DIV, rand_word());
		// ignored action codes
		send_cmd(ACT_SPARE_A, '1);
		send_cmd(ACT_SPARE_B, '1);
		send_cmd(ACT_SPARE_C, '1);

		run_random(RANDOM_ITEMS);

		// hold off until every result is back
		wait_drained();
		send_idle_pct = 80;
		recv_stall_pct = 11;
		run_random(RANDOM_ITEMS);

		send_idle_pct = 0;
		recv_stall_pct = 0;
		run_random(RANDOM_ITEMS);

		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (tracker.errs == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
